/* rtl/core/lsmc_pkg.sv */
// ----------------------------------------------------------------------------
// lsmc_pkg: shared types and constants for the line substring match counter
// Holds item structs, the item classes, register indexes and pattern setup.
// ----------------------------------------------------------------------------
package lsmc_pkg;

	// Line and pattern geometry
	localparam int LINE_MAX     = 4096;
	localparam int PATTERN_MAX  = 16;
	localparam int WINDOW_DEPTH = 16;
	localparam int FILL_W       = $clog2(LINE_MAX);
	localparam int PLEN_W       = 5;

	// Stream bytes with special meaning
	localparam logic [7:0] NEWLINE_BYTE = 8'd10;
	localparam logic [7:0] ZERO_BYTE    = 8'd0;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// Input operation codes
	localparam logic OP_DATA = 1'b0;
	localparam logic OP_END  = 1'b1;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_PATTERN_LOW    = 2'd0,
		CFG_PATTERN_HIGH   = 2'd1,
		CFG_PATTERN_LENGTH = 2'd2,
		CFG_MAX_LINES      = 2'd3
	} cfg_index_e;

	// Class of an item as decided by the front
	typedef enum logic [1:0] {
		CLS_BYTE    = 2'd0,
		CLS_ZERO    = 2'd1,
		CLS_NEWLINE = 2'd2,
		CLS_END     = 2'd3
	} item_class_e;

	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] line_index;
		logic [11:0] kept_length;
		logic        limit_reached;
	} out_item_t;

	typedef struct packed {
		item_class_e cls;
		logic [7:0]  data_byte;
	} queue_item_t;

	// Pattern laid out against the window: entry k holds the byte that the
	// k-th newest window byte must equal; mask marks entries in use.
	typedef struct packed {
		logic [WINDOW_DEPTH-1:0][7:0] aligned;
		logic [WINDOW_DEPTH-1:0]      mask;
		logic                         empty;
	} pattern_t;

	// Trim the pattern at its first zero byte and align it to the window
	function automatic pattern_t prep_pattern(input logic [63:0] low,
		input logic [63:0] high, input logic [PLEN_W-1:0] len);
		logic [WINDOW_DEPTH-1:0][7:0] bytes;
		logic [PLEN_W-1:0]            clamp;
		logic [PLEN_W-1:0]            eff;
		logic [PLEN_W-1:0]            idx;
		logic                         found;
		pattern_t                     p;
		bytes = {high, low};
		clamp = (len > PLEN_W'(PATTERN_MAX)) ? PLEN_W'(PATTERN_MAX) : len;
		eff   = clamp;
		found = 1'b0;
		for (int k = 0; k < WINDOW_DEPTH; k++) begin
			if (!found && (PLEN_W'(k) < clamp) && (bytes[k] == ZERO_BYTE)) begin
				eff   = PLEN_W'(k);
				found = 1'b1;
			end
		end
		for (int k = 0; k < WINDOW_DEPTH; k++) begin
			idx = eff - PLEN_W'(1) - PLEN_W'(k);
			p.mask[k] = (PLEN_W'(k) < eff);
			p.aligned[k] = p.mask[k] ? bytes[idx[$clog2(WINDOW_DEPTH)-1:0]] : ZERO_BYTE;
		end
		p.empty = (eff == '0);
		return p;
	endfunction

endpackage

/* rtl/core/lsmc_cfg.sv */
// ----------------------------------------------------------------------------
// lsmc_cfg: configuration registers
// Holds the pattern and max line count and keeps a window-aligned copy of
// the pattern ready for the back part.
// ----------------------------------------------------------------------------
module lsmc_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [1:0]                   cfg_index,
	input  logic [63:0]                  cfg_data,
	output lsmc_pkg::pattern_t           pattern,
	output logic [15:0]                  max_lines
);
	import lsmc_pkg::*;

	logic [63:0]       pat_low_q;
	logic [63:0]       pat_high_q;
	logic [PLEN_W-1:0] pat_len_q;
	logic [15:0]       max_lines_q;
	pattern_t          pattern_q;

	// Accept writes every cycle
	assign cfg_ready = 1'b1;

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q   <= '0;
			pat_high_q  <= '0;
			pat_len_q   <= '0;
			max_lines_q <= 16'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_e'(cfg_index))
				CFG_PATTERN_LOW:    pat_low_q   <= cfg_data;
				CFG_PATTERN_HIGH:   pat_high_q  <= cfg_data;
				CFG_PATTERN_LENGTH: pat_len_q   <= cfg_data[PLEN_W-1:0];
				CFG_MAX_LINES:      max_lines_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Refresh the aligned pattern from the registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= prep_pattern('0, '0, '0);
		end else begin
			pattern_q <= prep_pattern(pat_low_q, pat_high_q, pat_len_q);
		end
	end

	assign pattern   = pattern_q;
	assign max_lines = max_lines_q;

endmodule

/* rtl/core/lsmc_front.sv */
// ----------------------------------------------------------------------------
// lsmc_front: input stage
// Accepts items, classifies each as plain byte, zero, newline or end of
// input, and hands them to the queue.
// ----------------------------------------------------------------------------
module lsmc_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  lsmc_pkg::in_item_t     in_item,
	output logic                   push,
	output lsmc_pkg::queue_item_t  push_item,
	input  logic                   queue_full
);
	import lsmc_pkg::*;

	logic        valid_s1;
	queue_item_t item_s1;
	queue_item_t classified;
	logic        advance;

	// Classify the incoming item
	always_comb begin
		classified.data_byte = in_item.data_byte;
		if (in_item.op == OP_END) begin
			classified.cls = CLS_END;
		end else if (in_item.data_byte == NEWLINE_BYTE) begin
			classified.cls = CLS_NEWLINE;
		end else if (in_item.data_byte == ZERO_BYTE) begin
			classified.cls = CLS_ZERO;
		end else begin
			classified.cls = CLS_BYTE;
		end
	end

	// Stage advances when empty or when the queue takes its item
	assign advance  = !valid_s1 || !queue_full;
	assign in_stall = !advance;
	assign push      = valid_s1 && !queue_full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	// Hold the payload until the queue takes it
	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			item_s1 <= classified;
		end
	end

endmodule

/* rtl/core/lsmc_queue.sv */
// ----------------------------------------------------------------------------
// lsmc_queue: short item queue
// Decouples the front from the back so that each side stalls on its own.
// ----------------------------------------------------------------------------
module lsmc_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  lsmc_pkg::queue_item_t  push_item,
	output logic                   full,
	input  logic                   pop,
	output lsmc_pkg::queue_item_t  pop_item,
	output logic                   not_empty
);
	import lsmc_pkg::*;

	queue_item_t         slots_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full      = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_item  = slots_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QUEUE_AW+1)'(1);
				2'b01:   count_q <= count_q - (QUEUE_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Store the pushed item
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* rtl/core/lsmc_back.sv */
// ----------------------------------------------------------------------------
// lsmc_back: line engine
// Shifts matchable bytes into a 16-byte window, compares the window with the
// pattern in parallel, closes lines and drives the output register.
// ----------------------------------------------------------------------------
module lsmc_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  lsmc_pkg::queue_item_t  q_item,
	output logic                   q_pop,
	input  lsmc_pkg::pattern_t     pattern,
	input  logic [15:0]            max_lines,
	output logic                   out_valid,
	input  logic                   out_stall,
	output lsmc_pkg::out_item_t    out_item
);
	import lsmc_pkg::*;

	logic [WINDOW_DEPTH-1:0][7:0] window_q;
	logic [FILL_W-1:0]            fill_q;
	logic                         zero_seen_q;
	logic                         has_match_q;
	logic [15:0]                  match_count_q;
	logic [31:0]                  line_counter_q;
	logic                         stopped_q;
	logic                         out_valid_q;
	out_item_t                    out_item_q;

	logic [WINDOW_DEPTH-1:0][7:0] shifted;
	logic [WINDOW_DEPTH-1:0]      eq;
	logic                         hit;
	logic                         active;
	logic                         close;
	logic                         report;
	logic                         keep;
	logic                         room;
	logic [15:0]                  count_inc;
	logic                         limit;

	// Take an item when the output register is free or being emptied
	assign q_pop = q_valid && (!out_valid_q || !out_stall);

	// Decide what the popped item does
	always_comb begin
		shifted[0] = q_item.data_byte;
		for (int k = 1; k < WINDOW_DEPTH; k++) begin
			shifted[k] = window_q[k-1];
		end
		for (int k = 0; k < WINDOW_DEPTH; k++) begin
			eq[k] = !pattern.mask[k] || (shifted[k] == pattern.aligned[k]);
		end
		hit       = !pattern.empty && (&eq);
		active    = !stopped_q && (max_lines != '0);
		room      = (fill_q != FILL_W'(LINE_MAX - 1));
		close     = active && ((q_item.cls == CLS_NEWLINE) ||
			((q_item.cls == CLS_END) && (fill_q != '0)));
		report    = close && (has_match_q || pattern.empty);
		keep      = active && room &&
			((q_item.cls == CLS_BYTE) || (q_item.cls == CLS_ZERO));
		count_inc = match_count_q + 16'd1;
		limit     = (count_inc >= max_lines);
	end

	// Update line and match state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q       <= '0;
			fill_q         <= '0;
			zero_seen_q    <= 1'b0;
			has_match_q    <= 1'b0;
			match_count_q  <= '0;
			line_counter_q <= '0;
			stopped_q      <= 1'b0;
		end else if (q_pop) begin
			if (close) begin
				window_q    <= '0;
				fill_q      <= '0;
				zero_seen_q <= 1'b0;
				has_match_q <= 1'b0;
				if (line_counter_q != '1) begin
					line_counter_q <= line_counter_q + 32'd1;
				end
				if (report) begin
					match_count_q <= count_inc;
					if (limit) begin
						stopped_q <= 1'b1;
					end
				end
			end else if (keep) begin
				fill_q <= fill_q + FILL_W'(1);
				if (!zero_seen_q) begin
					if (q_item.cls == CLS_ZERO) begin
						zero_seen_q <= 1'b1;
					end else begin
						window_q <= shifted;
						if (hit) begin
							has_match_q <= 1'b1;
						end
					end
				end
			end
		end
	end

	// Drop the shown item once taken, load a new report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop && report) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && report) begin
			out_item_q.line_index    <= line_counter_q;
			out_item_q.kept_length   <= 12'(fill_q);
			out_item_q.limit_reached <= limit;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

/* rtl/core/line_substring_match_counter.sv */
// A closing item passes the front register and queue, then its result is registered.
// Throughput: one item per cycle unless stalled; the window compare decides each byte.
// A 4-entry queue between front and back lets either side stall on its own.
// Reset (arst_n low, asynchronous): line state, counters and queue clear,
// pattern is empty and max_lines is 1; no clearing pass is needed.
// ----------------------------------------------------------------------------
// line_substring_match_counter: top level
// Splits a byte stream into lines and reports lines holding a fixed pattern.
// ----------------------------------------------------------------------------
module line_substring_match_counter (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  lsmc_pkg::in_item_t    in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output lsmc_pkg::out_item_t   out_item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [63:0]           cfg_data
);
	import lsmc_pkg::*;

	pattern_t    pattern;
	logic [15:0] max_lines;
	logic        push;
	queue_item_t push_item;
	logic        queue_full;
	logic        pop;
	queue_item_t pop_item;
	logic        not_empty;

	lsmc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pattern   (pattern),
		.max_lines (max_lines)
	);

	lsmc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.push       (push),
		.push_item  (push_item),
		.queue_full (queue_full)
	);

	lsmc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.not_empty (not_empty)
	);

	lsmc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (not_empty),
		.q_item    (pop_item),
		.q_pop     (pop),
		.pattern   (pattern),
		.max_lines (max_lines),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

/* rtl/core/lsmc_checker.sv */
// ----------------------------------------------------------------------------
// lsmc_checker: port-level checks
// Watches the result channel for holding, ordering and stop behavior.
// ----------------------------------------------------------------------------
module lsmc_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  lsmc_pkg::out_item_t  out_item
);
	import lsmc_pkg::*;

	logic [31:0] last_index_q;
	logic        seen_q;

	// Track the line number of the last item taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q       <= 1'b0;
			last_index_q <= '0;
		end else if (out_valid && !out_stall) begin
			seen_q       <= 1'b1;
			last_index_q <= out_item.line_index;
		end
	end

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// Line numbers rise from one report to the next, unless saturated
	a_index_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_q |->
			(out_item.line_index > last_index_q) ||
			((out_item.line_index == '1) && (last_index_q == '1)))
		else $error("line numbers out of order");

	// Nothing follows the report that reached the limit
	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_item.limit_reached |=> !out_valid)
		else $error("result after limit reached");

endmodule

bind line_substring_match_counter lsmc_checker u_lsmc_checker (.*);
